// ===== hw/rtl/bfs_pkg.sv =====
package bfs_pkg;

    localparam int unsigned BurstShotsDefault = 3;

    typedef enum logic [2:0] {
        ST_RESTART      = 3'd0,
        ST_WAITING      = 3'd1,
        ST_TRIGGERED    = 3'd2,
        ST_START_MOTORS = 3'd3,
        ST_START_FEED   = 3'd4,
        ST_WAIT_LOW     = 3'd5,
        ST_WAIT_HIGH    = 3'd6,
        ST_STOPPING     = 3'd7
    } state_t;

    typedef enum logic [2:0] {
        CFG_LAUNCHER_MIN = 3'd0,
        CFG_LAUNCHER_MAX = 3'd1,
        CFG_FEEDER_MIN   = 3'd2,
        CFG_FEEDER_MAX   = 3'd3,
        CFG_SPEED_HIGH   = 3'd4,
        CFG_SPEED_LOW    = 3'd5,
        CFG_SPINUP_MS    = 3'd6,
        CFG_DWELL_MS     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  launcher_min_position;
        logic [7:0]  launcher_max_position;
        logic [7:0]  feeder_min_position;
        logic [7:0]  feeder_max_position;
        logic [7:0]  speed_high;
        logic [7:0]  speed_low;
        logic [15:0] spinup_ms;
        logic [15:0] dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        motors_enabled;
        logic        battle_mode;
        logic        fire_request_n;
        logic        feeder_sensor;
        logic        burst_mode;
        logic        high_velocity;
    } tick_t;

    typedef struct packed {
        logic       launcher_write;
        logic [7:0] launcher_position;
        logic       feeder_write;
        logic [7:0] feeder_position;
        state_t     sequencer_state;
        logic [7:0] shot_count;
    } result_t;

endpackage

// ===== hw/rtl/bfs_cfg_regs.sv =====
module bfs_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output bfs_pkg::cfg_t     cfg
);

    bfs_pkg::cfg_t cfg_reg;
    bfs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (bfs_pkg::cfg_index_t'(cfg_index))
                bfs_pkg::CFG_LAUNCHER_MIN: cfg_next.launcher_min_position = cfg_data[7:0];
                bfs_pkg::CFG_LAUNCHER_MAX: cfg_next.launcher_max_position = cfg_data[7:0];
                bfs_pkg::CFG_FEEDER_MIN:   cfg_next.feeder_min_position   = cfg_data[7:0];
                bfs_pkg::CFG_FEEDER_MAX:   cfg_next.feeder_max_position   = cfg_data[7:0];
                bfs_pkg::CFG_SPEED_HIGH:   cfg_next.speed_high            = cfg_data[7:0];
                bfs_pkg::CFG_SPEED_LOW:    cfg_next.speed_low             = cfg_data[7:0];
                bfs_pkg::CFG_SPINUP_MS:    cfg_next.spinup_ms             = cfg_data;
                bfs_pkg::CFG_DWELL_MS:     cfg_next.dwell_ms              = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launcher_min_position <= 8'd0;
            cfg_reg.launcher_max_position <= 8'd180;
            cfg_reg.feeder_min_position   <= 8'd90;
            cfg_reg.feeder_max_position   <= 8'd180;
            cfg_reg.speed_high            <= 8'd100;
            cfg_reg.speed_low             <= 8'd50;
            cfg_reg.spinup_ms             <= 16'd10;
            cfg_reg.dwell_ms              <= 16'd500;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/bfs_step.sv =====
module bfs_step #(
    parameter int unsigned BURST_SHOTS = bfs_pkg::BurstShotsDefault
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  bfs_pkg::tick_t   tick,
    input  bfs_pkg::cfg_t    cfg,
    output bfs_pkg::result_t result
);

    localparam logic [7:0] BurstLimit = 8'(BURST_SHOTS);

    bfs_pkg::state_t state_reg;
    bfs_pkg::state_t state_next;
    logic [31:0]     wait_start_reg;
    logic [31:0]     wait_start_next;
    logic [15:0]     wait_length_reg;
    logic [15:0]     wait_length_next;
    logic [7:0]      shots_reg;
    logic [7:0]      shots_next;

    logic            force_restart;
    logic [31:0]     deadline;
    logic            run;
    logic [7:0]      speed;
    logic [7:0]      launch_cmd;

    assign force_restart = (!tick.motors_enabled || !tick.battle_mode)
                           && (state_reg != bfs_pkg::ST_WAITING);
    assign deadline      = wait_start_reg + {16'd0, wait_length_reg};
    assign run           = force_restart || !(tick.now_ms < deadline);
    assign speed         = tick.high_velocity ? cfg.speed_high : cfg.speed_low;
    assign launch_cmd    = (cfg.launcher_max_position < speed) ? cfg.launcher_max_position
                                                               : speed;

    // next state and timer
    always_comb
    begin
        bfs_pkg::state_t cur;
        cur              = force_restart ? bfs_pkg::ST_RESTART : state_reg;
        state_next       = cur;
        wait_start_next  = wait_start_reg;
        wait_length_next = wait_length_reg;
        shots_next       = shots_reg;
        if (run)
        begin
            unique case (cur)
                bfs_pkg::ST_RESTART, bfs_pkg::ST_WAITING:
                begin
                    if (cur == bfs_pkg::ST_RESTART)
                    begin
                        shots_next = 8'd0;
                        state_next = bfs_pkg::ST_WAITING;
                    end
                    if (!tick.fire_request_n)
                        state_next = bfs_pkg::ST_TRIGGERED;
                end
                bfs_pkg::ST_TRIGGERED, bfs_pkg::ST_START_MOTORS:
                begin
                    state_next       = bfs_pkg::ST_START_FEED;
                    wait_length_next = cfg.spinup_ms;
                    wait_start_next  = tick.now_ms;
                end
                bfs_pkg::ST_START_FEED:
                begin
                    shots_next       = shots_reg + 8'd1;
                    state_next       = bfs_pkg::ST_WAIT_LOW;
                    wait_length_next = 16'd0;
                    wait_start_next  = tick.now_ms;
                end
                bfs_pkg::ST_WAIT_LOW:
                begin
                    if (!tick.feeder_sensor)
                    begin
                        state_next       = bfs_pkg::ST_WAIT_HIGH;
                        wait_length_next = 16'd0;
                        wait_start_next  = tick.now_ms;
                    end
                end
                bfs_pkg::ST_WAIT_HIGH:
                begin
                    if (tick.feeder_sensor)
                    begin
                        state_next       = bfs_pkg::ST_STOPPING;
                        wait_length_next = 16'd0;
                        wait_start_next  = tick.now_ms;
                    end
                end
                bfs_pkg::ST_STOPPING:
                begin
                    wait_length_next = cfg.dwell_ms;
                    wait_start_next  = tick.now_ms;
                    if (!tick.burst_mode || shots_reg >= BurstLimit)
                        state_next = bfs_pkg::ST_RESTART;
                    else
                        state_next = bfs_pkg::ST_START_FEED;
                end
                default:
                begin
                    state_next = cur;
                end
            endcase
        end
    end

    // servo write outputs plus reported state and shot count
    always_comb
    begin
        bfs_pkg::state_t cur;
        cur                      = force_restart ? bfs_pkg::ST_RESTART : state_reg;
        result                   = '0;
        result.sequencer_state   = state_next;
        result.shot_count        = shots_next;
        if (run)
        begin
            unique case (cur)
                bfs_pkg::ST_RESTART:
                begin
                    result.launcher_write    = 1'b1;
                    result.launcher_position = cfg.launcher_min_position;
                    result.feeder_write      = 1'b1;
                    result.feeder_position   = cfg.feeder_min_position;
                end
                bfs_pkg::ST_TRIGGERED, bfs_pkg::ST_START_MOTORS:
                begin
                    result.launcher_write    = 1'b1;
                    result.launcher_position = launch_cmd;
                end
                bfs_pkg::ST_START_FEED:
                begin
                    result.feeder_write    = 1'b1;
                    result.feeder_position = cfg.feeder_max_position;
                end
                bfs_pkg::ST_STOPPING:
                begin
                    result.feeder_write    = 1'b1;
                    result.feeder_position = cfg.feeder_min_position;
                end
                default:
                begin
                    result.launcher_write = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bfs_pkg::ST_WAITING;
            wait_start_reg  <= 32'd0;
            wait_length_reg <= 16'd0;
            shots_reg       <= 8'd0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            wait_start_reg  <= wait_start_next;
            wait_length_reg <= wait_length_next;
            shots_reg       <= shots_next;
        end
    end

    a_shots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        shots_reg <= BurstLimit)
        else $error("shot count above burst limit");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(shots_reg) && $stable(wait_start_reg))
        else $error("sequencer state moved without a tick");

    a_feed_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && run && !force_restart && state_reg == bfs_pkg::ST_START_FEED
        |=> shots_reg == $past(shots_reg) + 8'd1 && state_reg == bfs_pkg::ST_WAIT_LOW)
        else $error("feed step did not count a shot");

    a_forced_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && force_restart
        |=> shots_reg == 8'd0
            && (state_reg == bfs_pkg::ST_WAITING || state_reg == bfs_pkg::ST_TRIGGERED))
        else $error("forced restart did not return to waiting");

endmodule

// ===== hw/rtl/burst_fire_sequencer_core.sv =====
// Firing sequencer advanced by one tick per input transaction. Each tick gives exactly
// one result transaction holding the servo writes of that tick, the new state and the
// shot count. A tick is registered at the input, evaluated in a single pass of logic
// (one 32-bit deadline add and compare plus the state decode) and the result is
// registered at the output, so one tick is taken every cycle unless out_stall holds;
// a result passes tick_reg, then result_reg. The output register lets the next tick
// enter while a result waits on out_stall. Config writes take effect on the next tick.
module burst_fire_sequencer_core #(
    parameter int unsigned BURST_SHOTS = bfs_pkg::BurstShotsDefault
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] now_ms,
    input  logic        motors_enabled,
    input  logic        battle_mode,
    input  logic        fire_request_n,
    input  logic        feeder_sensor,
    input  logic        burst_mode,
    input  logic        high_velocity,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        launcher_write,
    output logic [7:0]  launcher_position,
    output logic        feeder_write,
    output logic [7:0]  feeder_position,
    output logic [2:0]  sequencer_state,
    output logic [7:0]  shot_count
);

    bfs_pkg::cfg_t    cfg;
    bfs_pkg::tick_t   tick_reg;
    logic             tick_valid_reg;
    bfs_pkg::result_t step_result;
    bfs_pkg::result_t result_reg;
    logic             result_valid_reg;

    logic             out_ready;
    logic             step;
    logic             in_take;

    assign out_ready = !result_valid_reg || !out_stall;
    assign step      = tick_valid_reg && out_ready;
    assign in_stall  = tick_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    bfs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bfs_step #(
        .BURST_SHOTS (BURST_SHOTS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (tick_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                tick_valid_reg <= 1'b1;
            else if (step)
                tick_valid_reg <= 1'b0;
            if (out_ready)
                result_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.now_ms         <= now_ms;
            tick_reg.motors_enabled <= motors_enabled;
            tick_reg.battle_mode    <= battle_mode;
            tick_reg.fire_request_n <= fire_request_n;
            tick_reg.feeder_sensor  <= feeder_sensor;
            tick_reg.burst_mode     <= burst_mode;
            tick_reg.high_velocity  <= high_velocity;
        end
        if (step)
            result_reg <= step_result;
    end

    assign out_valid         = result_valid_reg;
    assign launcher_write    = result_reg.launcher_write;
    assign launcher_position = result_reg.launcher_position;
    assign feeder_write      = result_reg.feeder_write;
    assign feeder_position   = result_reg.feeder_position;
    assign sequencer_state   = result_reg.sequencer_state;
    assign shot_count        = result_reg.shot_count;

endmodule

// ===== dv/burst_fire_sequencer_core_tb.sv =====
module burst_fire_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] now_ms = 32'd0;
    logic        motors_enabled = 1'b0;
    logic        battle_mode = 1'b0;
    logic        fire_request_n = 1'b1;
    logic        feeder_sensor = 1'b0;
    logic        burst_mode = 1'b0;
    logic        high_velocity = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        launcher_write;
    logic [7:0]  launcher_position;
    logic        feeder_write;
    logic [7:0]  feeder_position;
    logic [2:0]  sequencer_state;
    logic [7:0]  shot_count;

    burst_fire_sequencer_core #(
        .BURST_SHOTS(bfs_pkg::BurstShotsDefault)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .now_ms(now_ms),
        .motors_enabled(motors_enabled),
        .battle_mode(battle_mode),
        .fire_request_n(fire_request_n),
        .feeder_sensor(feeder_sensor),
        .burst_mode(burst_mode),
        .high_velocity(high_velocity),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .launcher_write(launcher_write),
        .launcher_position(launcher_position),
        .feeder_write(feeder_write),
        .feeder_position(feeder_position),
        .sequencer_state(sequencer_state),
        .shot_count(shot_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sequencer shadow: settings and firing state
    bfs_pkg::cfg_t   shadow_cfg;
    bfs_pkg::state_t seq_state = bfs_pkg::ST_WAITING;
    logic [31:0]     timer_start = 32'd0;
    logic [15:0]     timer_len = 16'd0;
    logic [7:0]      shots = 8'd0;

    bfs_pkg::tick_t   tick_q[$];
    bfs_pkg::result_t firing_expect_q[$];
    bfs_pkg::tick_t   next_tick;
    bfs_pkg::result_t want_res;
    logic [31:0]      clock_ms = 32'd0;
    int unsigned      mismatches = 0;
    int unsigned      cycle_count = 0;
    int unsigned      drv_gap = 0;
    int unsigned      mon_hold = 0;
    int unsigned      stretch_left[2] = '{0, 0};
    bit               calm[2] = '{1'b0, 1'b0};

    function automatic bfs_pkg::result_t predict_firing(bfs_pkg::tick_t t);
        bfs_pkg::result_t r;
        logic [31:0]      deadline;
        logic [7:0]       speed;
        logic             run;
        r = '0;
        run = 1'b1;
        if ((!t.motors_enabled || !t.battle_mode) && seq_state != bfs_pkg::ST_WAITING)
            seq_state = bfs_pkg::ST_RESTART;
        else
        begin
            deadline = timer_start + 32'(timer_len);
            if (t.now_ms < deadline)
                run = 1'b0;
        end
        if (run)
        begin
            case (seq_state)
                bfs_pkg::ST_RESTART, bfs_pkg::ST_WAITING:
                begin
                    // restart drops straight into waiting within the same tick
                    if (seq_state == bfs_pkg::ST_RESTART)
                    begin
                        r.launcher_write = 1'b1;
                        r.launcher_position = shadow_cfg.launcher_min_position;
                        r.feeder_write = 1'b1;
                        r.feeder_position = shadow_cfg.feeder_min_position;
                        shots = 8'd0;
                        seq_state = bfs_pkg::ST_WAITING;
                    end
                    if (!t.fire_request_n)
                        seq_state = bfs_pkg::ST_TRIGGERED;
                end
                bfs_pkg::ST_TRIGGERED, bfs_pkg::ST_START_MOTORS:
                begin
                    speed = t.high_velocity ? shadow_cfg.speed_high : shadow_cfg.speed_low;
                    r.launcher_write = 1'b1;
                    r.launcher_position = (shadow_cfg.launcher_max_position < speed) ?
                                          shadow_cfg.launcher_max_position : speed;
                    seq_state = bfs_pkg::ST_START_FEED;
                    timer_len = shadow_cfg.spinup_ms;
                    timer_start = t.now_ms;
                end
                bfs_pkg::ST_START_FEED:
                begin
                    shots = shots + 8'd1;
                    r.feeder_write = 1'b1;
                    r.feeder_position = shadow_cfg.feeder_max_position;
                    seq_state = bfs_pkg::ST_WAIT_LOW;
                    timer_len = 16'd0;
                    timer_start = t.now_ms;
                end
                bfs_pkg::ST_WAIT_LOW:
                begin
                    if (!t.feeder_sensor)
                    begin
                        seq_state = bfs_pkg::ST_WAIT_HIGH;
                        timer_len = 16'd0;
                        timer_start = t.now_ms;
                    end
                end
                bfs_pkg::ST_WAIT_HIGH:
                begin
                    if (t.feeder_sensor)
                    begin
                        seq_state = bfs_pkg::ST_STOPPING;
                        timer_len = 16'd0;
                        timer_start = t.now_ms;
                    end
                end
                default:
                begin
                    r.feeder_write = 1'b1;
                    r.feeder_position = shadow_cfg.feeder_min_position;
                    timer_len = shadow_cfg.dwell_ms;
                    timer_start = t.now_ms;
                    if (!t.burst_mode || shots >= bfs_pkg::BurstShotsDefault)
                        seq_state = bfs_pkg::ST_RESTART;
                    else
                        seq_state = bfs_pkg::ST_START_FEED;
                end
            endcase
        end
        r.sequencer_state = seq_state;
        r.shot_count = shots;
        return r;
    endfunction

    // stretches without waits and stretches of random waits, picked at random per stretch
    function automatic int unsigned draw_wait(int side);
        if (stretch_left[side] == 0)
        begin
            stretch_left[side] = $urandom_range(8, 40);
            calm[side] = ($urandom_range(0, 2) == 0);
        end
        stretch_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                firing_expect_q.push_back(predict_firing(bfs_pkg::tick_t'({now_ms,
                    motors_enabled, battle_mode, fire_request_n, feeder_sensor, burst_mode,
                    high_velocity})));
            if (drv_gap > 0)
            begin
                drv_gap--;
                in_valid <= 1'b0;
            end
            else if (tick_q.size() != 0)
            begin
                next_tick = tick_q.pop_front();
                now_ms <= next_tick.now_ms;
                motors_enabled <= next_tick.motors_enabled;
                battle_mode <= next_tick.battle_mode;
                fire_request_n <= next_tick.fire_request_n;
                feeder_sensor <= next_tick.feeder_sensor;
                burst_mode <= next_tick.burst_mode;
                high_velocity <= next_tick.high_velocity;
                in_valid <= 1'b1;
                drv_gap = draw_wait(SIDE_SEND);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (firing_expect_q.size() == 0)
                begin
                    $display("%0t: result transaction with no expectation waiting", $time);
                    mismatches++;
                end
                else
                begin
                    want_res = firing_expect_q.pop_front();
                    check_field("launcher_write", want_res.launcher_write, launcher_write);
                    check_field("launcher_position", want_res.launcher_position,
                                launcher_position);
                    check_field("feeder_write", want_res.feeder_write, feeder_write);
                    check_field("feeder_position", want_res.feeder_position, feeder_position);
                    check_field("sequencer_state", want_res.sequencer_state, sequencer_state);
                    check_field("shot_count", want_res.shot_count, shot_count);
                end
                mon_hold = draw_wait(SIDE_RECV);
            end
            if (mon_hold > 0)
            begin
                out_stall <= 1'b1;
                mon_hold--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     firing_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_tick(logic [31:0] t_now, bit en, bit bat, bit fire_n, bit sensor,
                             bit burst, bit high);
        tick_q.push_back(bfs_pkg::tick_t'({t_now, en, bat, fire_n, sensor, burst, high}));
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_q.size() != 0 || in_valid || firing_expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(bfs_pkg::cfg_index_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            bfs_pkg::CFG_LAUNCHER_MIN: shadow_cfg.launcher_min_position = value[7:0];
            bfs_pkg::CFG_LAUNCHER_MAX: shadow_cfg.launcher_max_position = value[7:0];
            bfs_pkg::CFG_FEEDER_MIN:   shadow_cfg.feeder_min_position = value[7:0];
            bfs_pkg::CFG_FEEDER_MAX:   shadow_cfg.feeder_max_position = value[7:0];
            bfs_pkg::CFG_SPEED_HIGH:   shadow_cfg.speed_high = value[7:0];
            bfs_pkg::CFG_SPEED_LOW:    shadow_cfg.speed_low = value[7:0];
            bfs_pkg::CFG_SPINUP_MS:    shadow_cfg.spinup_ms = value;
            default:                   shadow_cfg.dwell_ms = value;
        endcase
    endtask

    task automatic program_regs(logic [7:0] l_min, logic [7:0] l_max, logic [7:0] f_min,
                                logic [7:0] f_max, logic [7:0] s_high, logic [7:0] s_low,
                                logic [15:0] spin, logic [15:0] dwell);
        write_reg(bfs_pkg::CFG_LAUNCHER_MIN, {8'd0, l_min});
        write_reg(bfs_pkg::CFG_LAUNCHER_MAX, {8'd0, l_max});
        write_reg(bfs_pkg::CFG_FEEDER_MIN, {8'd0, f_min});
        write_reg(bfs_pkg::CFG_FEEDER_MAX, {8'd0, f_max});
        write_reg(bfs_pkg::CFG_SPEED_HIGH, {8'd0, s_high});
        write_reg(bfs_pkg::CFG_SPEED_LOW, {8'd0, s_low});
        write_reg(bfs_pkg::CFG_SPINUP_MS, spin);
        write_reg(bfs_pkg::CFG_DWELL_MS, dwell);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // mostly armed ticks with time moving forward, plus some noise
    task automatic queue_volley(int unsigned count);
        bfs_pkg::tick_t t;
        int unsigned    pick;
        int unsigned    slow;
        slow = 32'((shadow_cfg.dwell_ms > shadow_cfg.spinup_ms) ?
                   shadow_cfg.dwell_ms : shadow_cfg.spinup_ms);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            t.now_ms = clock_ms;
            t.motors_enabled = 1'b1;
            t.battle_mode = 1'b1;
            t.fire_request_n = ($urandom_range(0, 3) == 0);
            t.feeder_sensor = 1'($urandom_range(0, 1));
            t.burst_mode = ($urandom_range(0, 3) != 0);
            t.high_velocity = 1'($urandom_range(0, 1));
            if (pick < 5)
            begin
                // random time with drive off: cannot move the wait timer
                t.now_ms = $urandom;
                t.motors_enabled = 1'($urandom_range(0, 1));
                t.battle_mode = t.motors_enabled ? 1'b0 : 1'($urandom_range(0, 1));
            end
            else if (pick < 12)
            begin
                {t.motors_enabled, t.battle_mode, t.fire_request_n, t.feeder_sensor,
                 t.burst_mode, t.high_velocity} = 6'($urandom_range(0, 63));
            end
            tick_q.push_back(t);
            if ($urandom_range(0, 4) == 0)
                clock_ms = clock_ms + $urandom_range(0, slow + slow / 4 + 1);
            else
                clock_ms = clock_ms + $urandom_range(0, 2);
        end
    endtask

    // block is idle here, so the shadow timer is current
    task automatic resync_clock();
        clock_ms = timer_start + 32'(timer_len) + $urandom_range(0, 3);
    endtask

    initial
    begin
        logic [31:0] t_ms;
        shadow_cfg = '{launcher_min_position: 8'd0, launcher_max_position: 8'd180,
                       feeder_min_position: 8'd90, feeder_max_position: 8'd180,
                       speed_high: 8'd100, speed_low: 8'd50,
                       spinup_ms: 16'd10, dwell_ms: 16'd500};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: disabled while waiting, forced restart, full burst, timer edges
        push_tick(32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        t_ms = 32'd1000;
        push_tick(t_ms, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_tick(t_ms, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        push_tick(t_ms + 1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        push_tick(t_ms + 5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        t_ms = t_ms + 11;
        for (int shot = 0; shot < bfs_pkg::BurstShotsDefault; shot++)
        begin
            push_tick(t_ms, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            if (shot == 0)
                push_tick(t_ms, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            push_tick(t_ms + 1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
            push_tick(t_ms + 1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            push_tick(t_ms + 2, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
            // next step lands exactly on the dwell deadline
            t_ms = t_ms + 502;
        end
        push_tick(t_ms, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        push_tick(t_ms, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        push_tick(t_ms + 3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        push_tick(t_ms + 13, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        push_tick(t_ms + 13, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        wait_idle();

        resync_clock();
        queue_volley(50);
        wait_idle();

        program_regs(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                     8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                     8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                     16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
        resync_clock();
        queue_volley(50);
        wait_idle();

        program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0);
        resync_clock();
        queue_volley(40);
        wait_idle();

        program_regs(8'd180, 8'd180, 8'd180, 8'd180, 8'd180, 8'd180, 16'hFFFF, 16'hFFFF);
        resync_clock();
        queue_volley(40);
        wait_idle();

        // run the millisecond clock across its wrap point
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 20)), 16'hFFFF);
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        queue_volley(40);
        wait_idle();

        repeat (4)
        begin
            program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 30)), 16'($urandom_range(0, 60)));
            resync_clock();
            queue_volley(45);
            wait_idle();
        end

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bfs_pkg.sv
hw/rtl/bfs_cfg_regs.sv
hw/rtl/bfs_step.sv
hw/rtl/burst_fire_sequencer_core.sv
dv/burst_fire_sequencer_core_tb.sv
